// ===== rtl/rmtm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmtm_pkg - shared types for the running median / trimmed mean unit
// Payload structs, register indexes, input codes and sequencer states.
// ----------------------------------------------------------------------------
package rmtm_pkg;

    typedef struct packed {
        logic        action;
        logic [15:0] sample;
    } in_item_t;

    typedef struct packed {
        logic [15:0] evicted_sample;
        logic [15:0] median;
        logic [23:0] trimmed_mean;
        logic [23:0] smoothed_mean;
    } out_item_t;

    localparam logic [1:0] CFG_SAMPLE_COUNT = 2'd0;
    localparam logic [1:0] CFG_TRIM_WINDOW  = 2'd1;
    localparam logic [1:0] CFG_FILL_VALUE   = 2'd2;

    localparam logic ACT_PUSH   = 1'b0;
    localparam logic ACT_REINIT = 1'b1;

    localparam logic [4:0] RESET_SAMPLE_COUNT = 5'd9;
    localparam logic [4:0] RESET_TRIM_WINDOW  = 5'd3;

    localparam logic [7:0] SMOOTH_OLD_GAIN = 8'd154;
    localparam logic [7:0] SMOOTH_NEW_GAIN = 8'd102;

    typedef enum logic [4:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_FILL,
        ST_RING_RD,
        ST_RING_EV,
        ST_SCAN_RD,
        ST_SCAN_EV,
        ST_SHIFT_RD,
        ST_SHIFT_WR,
        ST_PLACE,
        ST_MED_RD,
        ST_MED_EV,
        ST_SUM_RD,
        ST_SUM_EV,
        ST_DIV,
        ST_SMOOTH_A,
        ST_SMOOTH_B,
        ST_FIN
    } state_t;

endpackage

// ===== rtl/rmtm_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmtm_ram - generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module rmtm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/running_median_trimmed_mean_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// running_median_trimmed_mean_unit - sliding window median / trimmed mean
// Ring of the last N samples plus a sorted copy, both in RAM, updated by a
// sequencer; trimmed mean by window sum and a bit-serial divider.
// ----------------------------------------------------------------------------
// Usage:
//   s_* channel takes one item per transfer: a push (new sample) or a
//   reinitialize. Each item gives exactly one result on the m_* channel:
//   the evicted sample, the median, the trimmed mean and the smoothed mean.
//   Configuration (sample_count, trim_window, fill_value) is written through
//   cfg_we/cfg_addr/cfg_wdata; the user must write it while the unit is idle.
// Flow (one item at a time, s_ready only in idle):
//   push with unchanged sample : ring swap, median read and smoothing only
//   push with changed sample   : scan and shift of the sorted RAM, then the
//                                median, plus a window sum and a divide
//                                unless trim_window is 0 or 1
//   reinitialize               : fill of all MAX_SAMPLES entries of both RAMs
//   The sorted RAM's single read port and the serial divider set the pace.
// Reset: a clearing pass over all MAX_SAMPLES entries zeroes both RAMs; s_ready
//   stays low meanwhile. Configuration writes are taken at any time.
// Stall: a finished result waits in the output register; the next item is
//   accepted and processed, and holds at the end until the register frees.
// ----------------------------------------------------------------------------
module running_median_trimmed_mean_unit #(
    parameter int MAX_SAMPLES = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  rmtm_pkg::in_item_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output rmtm_pkg::out_item_t m_data,
    input  logic                cfg_we,
    input  logic [1:0]          cfg_addr,
    input  logic [15:0]         cfg_wdata
);

    localparam int AW    = $clog2(MAX_SAMPLES);
    localparam int NW    = $clog2(MAX_SAMPLES + 1);
    localparam int SUM_W = 16 + NW;
    localparam int DW    = SUM_W + 8;
    localparam int DCW   = $clog2(DW + 1);

    // configuration
    logic [4:0]  sample_count_reg;
    logic [4:0]  trim_window_reg;
    logic [15:0] fill_value_reg;

    // sequencer state
    rmtm_pkg::state_t state_reg, state_next;
    logic [AW-1:0]    last_index_reg, last_index_next;
    logic [23:0]      mean_reg, mean_next;
    logic [23:0]      smoothed_reg, smoothed_next;
    logic [AW-1:0]    idx_reg, idx_next;        // sweep / scan / shift / sum index
    logic [AW-1:0]    cnt_reg, cnt_next;        // shift moves left
    logic [AW-1:0]    place_reg, place_next;
    logic [AW-1:0]    sum_hi_reg, sum_hi_next;
    logic [AW-1:0]    pos_reg, pos_next;
    logic             pos_found_reg, pos_found_next;
    logic [AW-1:0]    left_reg, left_next;
    logic             left_found_reg, left_found_next;
    logic             shift_up_reg, shift_up_next;
    logic             changed_reg, changed_next;
    logic [15:0]      new_reg, new_next;
    logic [15:0]      evicted_reg, evicted_next;
    logic [15:0]      median_reg, median_next;
    logic [15:0]      slast_reg, slast_next;
    logic [SUM_W-1:0] acc_reg, acc_next;
    logic [NW-1:0]    divisor_reg, divisor_next;
    logic [NW-1:0]    rem_reg, rem_next;
    logic [DW-1:0]    quo_reg, quo_next;
    logic [DCW-1:0]   div_cnt_reg, div_cnt_next;
    logic [31:0]      prod_reg, prod_next;
    logic             m_valid_reg, m_valid_next;
    rmtm_pkg::out_item_t out_reg, out_next;

    // RAM ports
    logic          ring_we, sort_we;
    logic [AW-1:0] ring_waddr, ring_raddr, sort_waddr, sort_raddr;
    logic [15:0]   ring_wdata, sort_wdata, ring_rdata, sort_rdata;

    rmtm_ram #(.WIDTH(16), .DEPTH(MAX_SAMPLES)) u_ring (
        .aclk(aclk), .we(ring_we), .waddr(ring_waddr), .wdata(ring_wdata),
        .raddr(ring_raddr), .rdata(ring_rdata)
    );

    rmtm_ram #(.WIDTH(16), .DEPTH(MAX_SAMPLES)) u_sorted (
        .aclk(aclk), .we(sort_we), .waddr(sort_waddr), .wdata(sort_wdata),
        .raddr(sort_raddr), .rdata(sort_rdata)
    );

    // effective window length, clamped to 1..MAX_SAMPLES
    logic [NW-1:0] n_len;
    logic [AW-1:0] n_m1, half;
    logic [NW-1:0] cur_wide;
    logic [AW-1:0] cur_idx;
    logic [AW-1:0] pos_fin, left_fin;
    logic [AW-1:0] win_end;
    logic [NW:0]   rem_shift;

    always_comb begin
        if (sample_count_reg == 5'd0) begin
            n_len = NW'(1);
        end else if (32'(sample_count_reg) > MAX_SAMPLES) begin
            n_len = NW'(MAX_SAMPLES);
        end else begin
            n_len = NW'(sample_count_reg);
        end
    end

    assign n_m1     = AW'(n_len - NW'(1));
    assign half     = AW'(n_len >> 1);
    assign cur_wide = NW'(last_index_reg) + NW'(1);
    assign cur_idx  = (cur_wide >= n_len) ? '0 : AW'(cur_wide);
    assign pos_fin  = pos_found_reg ? pos_reg : '0;
    assign left_fin = left_found_reg ? left_reg : '0;
    assign win_end  = AW'(32'(half) + 32'(trim_window_reg >> 1));
    assign rem_shift = {rem_reg, quo_reg[DW-1]};

    assign s_ready = (state_reg == rmtm_pkg::ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

    // configuration writes: taken whenever the enable is high
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sample_count_reg <= rmtm_pkg::RESET_SAMPLE_COUNT;
            trim_window_reg  <= rmtm_pkg::RESET_TRIM_WINDOW;
            fill_value_reg   <= '0;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                rmtm_pkg::CFG_SAMPLE_COUNT: sample_count_reg <= cfg_wdata[4:0];
                rmtm_pkg::CFG_TRIM_WINDOW:  trim_window_reg  <= cfg_wdata[4:0];
                rmtm_pkg::CFG_FILL_VALUE:   fill_value_reg   <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= rmtm_pkg::ST_CLEAR;
            last_index_reg <= AW'(rmtm_pkg::RESET_SAMPLE_COUNT - 5'd1);
            mean_reg       <= '0;
            smoothed_reg   <= '0;
            idx_reg        <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            last_index_reg <= last_index_next;
            mean_reg       <= mean_next;
            smoothed_reg   <= smoothed_next;
            idx_reg        <= idx_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    // payload and working registers
    always_ff @(posedge aclk) begin
        cnt_reg        <= cnt_next;
        place_reg      <= place_next;
        sum_hi_reg     <= sum_hi_next;
        pos_reg        <= pos_next;
        pos_found_reg  <= pos_found_next;
        left_reg       <= left_next;
        left_found_reg <= left_found_next;
        shift_up_reg   <= shift_up_next;
        changed_reg    <= changed_next;
        new_reg        <= new_next;
        evicted_reg    <= evicted_next;
        median_reg     <= median_next;
        slast_reg      <= slast_next;
        acc_reg        <= acc_next;
        divisor_reg    <= divisor_next;
        rem_reg        <= rem_next;
        quo_reg        <= quo_next;
        div_cnt_reg    <= div_cnt_next;
        prod_reg       <= prod_next;
        out_reg        <= out_next;
    end

    always_comb begin
        logic [31:0] mix;
        state_next      = state_reg;
        last_index_next = last_index_reg;
        mean_next       = mean_reg;
        smoothed_next   = smoothed_reg;
        idx_next        = idx_reg;
        cnt_next        = cnt_reg;
        place_next      = place_reg;
        sum_hi_next     = sum_hi_reg;
        pos_next        = pos_reg;
        pos_found_next  = pos_found_reg;
        left_next       = left_reg;
        left_found_next = left_found_reg;
        shift_up_next   = shift_up_reg;
        changed_next    = changed_reg;
        new_next        = new_reg;
        evicted_next    = evicted_reg;
        median_next     = median_reg;
        slast_next      = slast_reg;
        acc_next        = acc_reg;
        divisor_next    = divisor_reg;
        rem_next        = rem_reg;
        quo_next        = quo_reg;
        div_cnt_next    = div_cnt_reg;
        prod_next       = prod_reg;
        out_next        = out_reg;
        mix             = '0;
        m_valid_next    = m_valid_reg;
        ring_we    = 1'b0;
        ring_waddr = idx_reg;
        ring_wdata = fill_value_reg;
        ring_raddr = cur_idx;
        sort_we    = 1'b0;
        sort_waddr = idx_reg;
        sort_wdata = fill_value_reg;
        sort_raddr = idx_reg;

        // drop the result once the receiver takes it
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            rmtm_pkg::ST_CLEAR: begin
                // zero both stores after reset
                ring_we    = 1'b1;
                sort_we    = 1'b1;
                ring_wdata = '0;
                sort_wdata = '0;
                idx_next   = idx_reg + AW'(1);
                if (32'(idx_reg) == MAX_SAMPLES - 1) begin
                    idx_next   = '0;
                    state_next = rmtm_pkg::ST_IDLE;
                end
            end
            rmtm_pkg::ST_IDLE: begin
                if (s_valid) begin
                    new_next    = s_data.sample;
                    idx_next    = '0;
                    if (s_data.action == rmtm_pkg::ACT_REINIT) begin
                        state_next = rmtm_pkg::ST_FILL;
                    end else begin
                        state_next = rmtm_pkg::ST_RING_RD;
                    end
                end
            end
            rmtm_pkg::ST_FILL: begin
                ring_we  = 1'b1;
                sort_we  = 1'b1;
                idx_next = idx_reg + AW'(1);
                if (32'(idx_reg) == MAX_SAMPLES - 1) begin
                    idx_next        = '0;
                    last_index_next = n_m1;
                    mean_next       = {fill_value_reg, 8'd0};
                    smoothed_next   = {fill_value_reg, 8'd0};
                    evicted_next    = fill_value_reg;
                    median_next     = fill_value_reg;
                    state_next      = rmtm_pkg::ST_FIN;
                end
            end
            rmtm_pkg::ST_RING_RD: begin
                ring_raddr = cur_idx;
                place_next = cur_idx;
                state_next = rmtm_pkg::ST_RING_EV;
            end
            rmtm_pkg::ST_RING_EV: begin
                // swap the new sample into the ring
                evicted_next    = ring_rdata;
                ring_we         = 1'b1;
                ring_waddr      = place_reg;
                ring_wdata      = new_reg;
                last_index_next = place_reg;
                changed_next    = (new_reg != ring_rdata);
                pos_found_next  = 1'b0;
                left_found_next = 1'b0;
                idx_next        = n_m1;
                if (new_reg != ring_rdata) begin
                    state_next = rmtm_pkg::ST_SCAN_RD;
                end else begin
                    state_next = rmtm_pkg::ST_MED_RD;
                end
            end
            rmtm_pkg::ST_SCAN_RD: begin
                sort_raddr = idx_reg;
                state_next = rmtm_pkg::ST_SCAN_EV;
            end
            rmtm_pkg::ST_SCAN_EV: begin
                // search from the top for the evicted value and the insert slot
                if (idx_reg == n_m1) begin
                    slast_next = sort_rdata;
                end
                if (!pos_found_reg && sort_rdata == evicted_reg) begin
                    pos_found_next = 1'b1;
                    pos_next       = idx_reg;
                end
                if (!left_found_reg && sort_rdata <= new_reg) begin
                    left_found_next = 1'b1;
                    left_next       = idx_reg;
                end
                if (idx_reg == '0) begin
                    priority if (new_reg <= sort_rdata) begin
                        shift_up_next = 1'b1;
                        idx_next      = pos_fin - AW'(1);
                        cnt_next      = pos_fin;
                        place_next    = '0;
                    end else if (new_reg >= ((n_m1 == '0) ? sort_rdata : slast_reg)) begin
                        shift_up_next = 1'b0;
                        idx_next      = pos_fin + AW'(1);
                        cnt_next      = n_m1 - pos_fin;
                        place_next    = n_m1;
                    end else if (pos_fin <= left_fin) begin
                        shift_up_next = 1'b0;
                        idx_next      = pos_fin + AW'(1);
                        cnt_next      = left_fin - pos_fin;
                        place_next    = left_fin;
                    end else begin
                        shift_up_next = 1'b1;
                        idx_next      = pos_fin - AW'(1);
                        cnt_next      = pos_fin - left_fin;
                        place_next    = left_fin + AW'(1);
                    end
                    state_next = rmtm_pkg::ST_SHIFT_RD;
                    if (cnt_next == '0) begin
                        state_next = rmtm_pkg::ST_PLACE;
                    end
                end else begin
                    idx_next   = idx_reg - AW'(1);
                    state_next = rmtm_pkg::ST_SCAN_RD;
                end
            end
            rmtm_pkg::ST_SHIFT_RD: begin
                sort_raddr = idx_reg;
                state_next = rmtm_pkg::ST_SHIFT_WR;
            end
            rmtm_pkg::ST_SHIFT_WR: begin
                // move one entry toward the hole left by the evicted value
                sort_we    = 1'b1;
                sort_wdata = sort_rdata;
                sort_waddr = shift_up_reg ? idx_reg + AW'(1) : idx_reg - AW'(1);
                idx_next   = shift_up_reg ? idx_reg - AW'(1) : idx_reg + AW'(1);
                cnt_next   = cnt_reg - AW'(1);
                if (cnt_reg == AW'(1)) begin
                    state_next = rmtm_pkg::ST_PLACE;
                end else begin
                    state_next = rmtm_pkg::ST_SHIFT_RD;
                end
            end
            rmtm_pkg::ST_PLACE: begin
                sort_we    = 1'b1;
                sort_waddr = place_reg;
                sort_wdata = new_reg;
                state_next = rmtm_pkg::ST_MED_RD;
            end
            rmtm_pkg::ST_MED_RD: begin
                sort_raddr = half;
                state_next = rmtm_pkg::ST_MED_EV;
            end
            rmtm_pkg::ST_MED_EV: begin
                median_next = sort_rdata;
                acc_next    = '0;
                state_next  = rmtm_pkg::ST_SMOOTH_A;
                if (changed_reg) begin
                    if (trim_window_reg <= 5'd1) begin
                        mean_next = {sort_rdata, 8'd0};
                    end else begin
                        if (32'(trim_window_reg) >= 32'(n_len)) begin
                            idx_next     = '0;
                            sum_hi_next  = n_m1;
                            divisor_next = n_len;
                        end else begin
                            idx_next     = AW'(32'(win_end) + 32'd1 - 32'(trim_window_reg));
                            sum_hi_next  = win_end;
                            divisor_next = NW'(trim_window_reg);
                        end
                        state_next = rmtm_pkg::ST_SUM_RD;
                    end
                end
            end
            rmtm_pkg::ST_SUM_RD: begin
                sort_raddr = idx_reg;
                state_next = rmtm_pkg::ST_SUM_EV;
            end
            rmtm_pkg::ST_SUM_EV: begin
                acc_next = acc_reg + SUM_W'(sort_rdata);
                idx_next = idx_reg + AW'(1);
                if (idx_reg == sum_hi_reg) begin
                    quo_next     = {acc_next, 8'd0};
                    rem_next     = '0;
                    div_cnt_next = DCW'(DW);
                    state_next   = rmtm_pkg::ST_DIV;
                end else begin
                    state_next = rmtm_pkg::ST_SUM_RD;
                end
            end
            rmtm_pkg::ST_DIV: begin
                // restoring division, one quotient bit per cycle
                if (rem_shift >= {1'b0, divisor_reg}) begin
                    rem_next = NW'(rem_shift - {1'b0, divisor_reg});
                    quo_next = {quo_reg[DW-2:0], 1'b1};
                end else begin
                    rem_next = NW'(rem_shift);
                    quo_next = {quo_reg[DW-2:0], 1'b0};
                end
                div_cnt_next = div_cnt_reg - DCW'(1);
                if (div_cnt_reg == DCW'(1)) begin
                    mean_next  = quo_next[23:0];
                    state_next = rmtm_pkg::ST_SMOOTH_A;
                end
            end
            rmtm_pkg::ST_SMOOTH_A: begin
                prod_next  = 32'(smoothed_reg) * 32'(rmtm_pkg::SMOOTH_OLD_GAIN);
                state_next = rmtm_pkg::ST_SMOOTH_B;
            end
            rmtm_pkg::ST_SMOOTH_B: begin
                mix           = prod_reg + 32'(mean_reg) * 32'(rmtm_pkg::SMOOTH_NEW_GAIN);
                smoothed_next = mix[31:8];
                state_next    = rmtm_pkg::ST_FIN;
            end
            rmtm_pkg::ST_FIN: begin
                // hold until the output register is free
                if (!m_valid_reg || m_ready) begin
                    out_next.evicted_sample = evicted_reg;
                    out_next.median         = median_reg;
                    out_next.trimmed_mean   = mean_reg;
                    out_next.smoothed_mean  = smoothed_reg;
                    m_valid_next            = 1'b1;
                    state_next              = rmtm_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = rmtm_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/rmtm_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmtm_checker - port-level assertions for the median / trimmed mean unit
// Checks result hold under stall, one item at a time and reset behavior.
// ----------------------------------------------------------------------------
module rmtm_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input logic                m_valid,
    input logic                m_ready,
    input rmtm_pkg::out_item_t m_data
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(m_data))
        else $error("result changed while stalled");

    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second transfer taken before the first finished");

    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !s_ready && !m_valid)
        else $error("unit active right after reset");

endmodule

bind running_median_trimmed_mean_unit rmtm_checker u_rmtm_checker (
    .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
    .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
);

// ===== dv/running_median_trimmed_mean_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// running_median_trimmed_mean_unit_tb - self-checking bench for the filter
// Drives pushes and reinitializes through the s_ channel, models the ring,
// the sorted copy and both Q16.8 means, and compares every m_ transfer.
// ----------------------------------------------------------------------------
module running_median_trimmed_mean_unit_tb;

    localparam int MAXN       = 16;
    localparam int CYCLE_CAP  = 1500000;
    localparam int DRAIN_WAIT = 200;

    logic                aclk;
    logic                aresetn;
    logic                s_valid;
    logic                s_ready;
    rmtm_pkg::in_item_t  s_data;
    logic                m_valid;
    logic                m_ready;
    rmtm_pkg::out_item_t m_data;
    logic                cfg_we;
    logic [1:0]          cfg_addr;
    logic [15:0]         cfg_wdata;

    running_median_trimmed_mean_unit #(.MAX_SAMPLES(MAXN)) dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
    );

    // Predictor state: a shadow of the registers and both stores.
    logic [4:0]  win_reg;
    logic [4:0]  trim_reg;
    logic [15:0] fill_reg;
    logic [15:0] ring [MAXN];
    logic [15:0] sorted [MAXN];
    int          wr_pos;
    logic [23:0] mean_q;
    logic [23:0] smooth_q;

    rmtm_pkg::in_item_t  pending_items[$];
    rmtm_pkg::out_item_t expected_results[$];
    int        errors;
    int        cycles;
    int        burst_left;
    int        gap_left;
    int        stall_phase;

    // Handshake seen at the last rising edge; decides if the driver may advance.
    logic s_ready_seen;

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    function automatic int window_len();
        if (win_reg < 1) return 1;
        if (win_reg > MAXN) return MAXN;
        return win_reg;
    endfunction

    // Take the replaced value out of the sorted copy and put the new one in.
    function automatic void reorder(int n, logic [15:0] oldv, logic [15:0] newv);
        int pos;
        int left;
        pos = 0;
        left = 0;
        // Missing old value (possible after N changed) counts as index 0.
        for (int i = n - 1; i >= 0; i--) begin
            if (sorted[i] == oldv) begin
                pos = i;
                break;
            end
        end
        if (newv <= sorted[0]) begin
            for (int i = pos; i > 0; i--) sorted[i] = sorted[i-1];
            sorted[0] = newv;
        end else if (newv >= sorted[n-1]) begin
            for (int i = pos; i < n - 1; i++) sorted[i] = sorted[i+1];
            sorted[n-1] = newv;
        end else begin
            for (int i = n - 1; i >= 0; i--) begin
                if (sorted[i] <= newv) begin
                    left = i;
                    break;
                end
            end
            if (pos <= left) begin
                for (int i = pos; i < left; i++) sorted[i] = sorted[i+1];
                sorted[left] = newv;
            end else begin
                for (int i = pos; i > left + 1; i--) sorted[i] = sorted[i-1];
                sorted[left+1] = newv;
            end
        end
    endfunction

    function automatic logic [23:0] trimmed_average(int n);
        int        w;
        int        lo;
        int        hi;
        longint    acc;
        w = trim_reg;
        acc = 0;
        if (w <= 1) return {sorted[n/2], 8'h00};
        if (w >= n) begin
            for (int i = 0; i < n; i++) acc += sorted[i];
            return 24'((acc << 8) / n);
        end
        hi = n / 2 + w / 2;
        lo = hi + 1 - w;
        for (int i = lo; i <= hi && i < n; i++) acc += sorted[i];
        return 24'((acc << 8) / w);
    endfunction

    function automatic rmtm_pkg::out_item_t predict_filter(rmtm_pkg::in_item_t item);
        rmtm_pkg::out_item_t res;
        int          n;
        int          cur;
        logic [15:0] gone;
        longint      mix;
        n = window_len();
        if (item.action == rmtm_pkg::ACT_REINIT) begin
            for (int i = 0; i < MAXN; i++) begin
                ring[i] = fill_reg;
                sorted[i] = fill_reg;
            end
            wr_pos = n - 1;
            mean_q = {fill_reg, 8'h00};
            smooth_q = mean_q;
            gone = fill_reg;
        end else begin
            // Stale write position (N shrank) wraps to the start.
            cur = wr_pos + 1;
            if (cur >= n) cur = 0;
            gone = ring[cur];
            ring[cur] = item.sample;
            wr_pos = cur;
            if (item.sample != gone) begin
                reorder(n, gone, item.sample);
                mean_q = trimmed_average(n);
            end
            mix = 154 * longint'(smooth_q) + 102 * longint'(mean_q);
            smooth_q = 24'(mix >> 8);
        end
        res.evicted_sample = gone;
        res.median = sorted[n/2];
        res.trimmed_mean = mean_q;
        res.smoothed_mean = smooth_q;
        return res;
    endfunction

    // Driver: bursts of transfers separated by random gaps.
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready_seen) begin
            if (gap_left > 0) begin
                gap_left = gap_left - 1;
                s_valid <= 1'b0;
            end else if (pending_items.size() > 0) begin
                s_data <= pending_items.pop_front();
                s_valid <= 1'b1;
                if (burst_left > 0) begin
                    burst_left = burst_left - 1;
                end else begin
                    burst_left = $urandom_range(0, 12);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 40);
                end
            end else begin
                s_valid <= 1'b0;
            end
        end
        // Receiver stalls in its own rhythm: long open windows and stall runs.
        stall_phase = (stall_phase + 1) % 64;
        m_ready <= (stall_phase < 24) ? 1'b1 : ($urandom_range(0, 3) != 0);
    end

    always @(posedge aclk) begin
        s_ready_seen <= s_valid && s_ready;
        if (aresetn && s_valid && s_ready) begin
            expected_results.push_back(predict_filter(s_data));
        end
    end

    // Monitor: compare each result transfer with the oldest expectation.
    always @(posedge aclk) begin
        rmtm_pkg::out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result %h", $time, m_data);
                errors++;
            end else begin
                want = expected_results.pop_front();
                if (m_data.evicted_sample !== want.evicted_sample)
                    $display("%0t: evicted exp %h got %h", $time,
                             want.evicted_sample, m_data.evicted_sample);
                if (m_data.median !== want.median)
                    $display("%0t: median exp %h got %h", $time,
                             want.median, m_data.median);
                if (m_data.trimmed_mean !== want.trimmed_mean)
                    $display("%0t: trimmed exp %h got %h", $time,
                             want.trimmed_mean, m_data.trimmed_mean);
                if (m_data.smoothed_mean !== want.smoothed_mean)
                    $display("%0t: smoothed exp %h got %h", $time,
                             want.smoothed_mean, m_data.smoothed_mean);
                if (m_data !== want) errors++;
            end
        end
    end

    // Watchdog: end a hung run.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_we <= 1'b0;
        case (idx)
            rmtm_pkg::CFG_SAMPLE_COUNT: win_reg = val[4:0];
            rmtm_pkg::CFG_TRIM_WINDOW:  trim_reg = val[4:0];
            default:                    fill_reg = val;
        endcase
    endtask

    // Hold until every queued item went out and every result came back.
    task automatic settle();
        while (pending_items.size() > 0 || s_valid || expected_results.size() > 0)
            @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
    endtask

    function automatic rmtm_pkg::in_item_t make_push(logic [15:0] v);
        rmtm_pkg::in_item_t it;
        it.action = rmtm_pkg::ACT_PUSH;
        it.sample = v;
        return it;
    endfunction

    function automatic rmtm_pkg::in_item_t make_reinit();
        rmtm_pkg::in_item_t it;
        it.action = rmtm_pkg::ACT_REINIT;
        it.sample = 16'($urandom);
        return it;
    endfunction

    // Random pushes and occasional reinitializes, mostly from a narrow range so values repeat often.
    task automatic queue_random(int count);
        for (int i = 0; i < count; i++) begin
            case ($urandom_range(0, 19))
                0:       pending_items.push_back(make_reinit());
                1, 2:    pending_items.push_back(make_push(16'($urandom)));
                3:       pending_items.push_back(
                             make_push($urandom_range(0, 1) ? 16'hFFFF : 16'h0000));
                default: pending_items.push_back(make_push(16'($urandom_range(100, 108))));
            endcase
        end
    endtask

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        m_ready = 1'b0;
        cfg_we = 1'b0;
        cfg_addr = rmtm_pkg::CFG_SAMPLE_COUNT;
        cfg_wdata = '0;
        errors = 0;
        cycles = 0;
        burst_left = 0;
        gap_left = 0;
        stall_phase = 0;
        s_ready_seen = 1'b0;
        win_reg = rmtm_pkg::RESET_SAMPLE_COUNT;
        trim_reg = rmtm_pkg::RESET_TRIM_WINDOW;
        fill_reg = '0;
        for (int i = 0; i < MAXN; i++) begin
            ring[i] = '0;
            sorted[i] = '0;
        end
        wr_pos = rmtm_pkg::RESET_SAMPLE_COUNT - 1;
        mean_q = '0;
        smooth_q = '0;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed: extremes, repeats and random pushes at reset settings.
        pending_items.push_back(make_push(16'hFFFF));
        pending_items.push_back(make_push(16'h0000));
        pending_items.push_back(make_push(16'h0000));
        pending_items.push_back(make_push(16'h8000));
        pending_items.push_back(make_push(16'h7FFF));
        pending_items.push_back(make_push(16'h5555));
        pending_items.push_back(make_push(16'hAAAA));
        for (int i = 0; i < 6; i++) pending_items.push_back(make_push(16'($urandom)));
        settle();

        // Shrink N below the window in use: evicted value may be missing from the sorted copy.
        write_reg(rmtm_pkg::CFG_SAMPLE_COUNT, 16'd4);
        write_reg(rmtm_pkg::CFG_TRIM_WINDOW, 16'd0);
        pending_items.push_back(make_push(16'h1234));
        pending_items.push_back(make_push(16'hFFFF));
        settle();
        write_reg(rmtm_pkg::CFG_FILL_VALUE, 16'hFFFF);
        pending_items.push_back(make_reinit());
        pending_items.push_back(make_push(16'hFFFF));
        pending_items.push_back(make_push(16'h0001));
        settle();
        write_reg(rmtm_pkg::CFG_SAMPLE_COUNT, 16'd0);
        write_reg(rmtm_pkg::CFG_TRIM_WINDOW, 16'd31);
        pending_items.push_back(make_push(16'h0002));
        pending_items.push_back(make_push(16'h0003));
        settle();
        write_reg(rmtm_pkg::CFG_SAMPLE_COUNT, 16'd31);
        pending_items.push_back(make_push(16'hFFFE));
        pending_items.push_back(make_push(16'h0000));
        settle();

        // Random phases through a spread of window and trim settings.
        for (int ph = 0; ph < 10; ph++) begin
            case (ph)
                0: begin
                    write_reg(rmtm_pkg::CFG_SAMPLE_COUNT, 16'd16);
                    write_reg(rmtm_pkg::CFG_TRIM_WINDOW, 16'd16);
                end
                1: begin
                    write_reg(rmtm_pkg::CFG_SAMPLE_COUNT, 16'd1);
                    write_reg(rmtm_pkg::CFG_TRIM_WINDOW, 16'd1);
                end
                2: begin
                    write_reg(rmtm_pkg::CFG_SAMPLE_COUNT, 16'd16);
                    write_reg(rmtm_pkg::CFG_TRIM_WINDOW, 16'd15);
                end
                default: begin
                    write_reg(rmtm_pkg::CFG_SAMPLE_COUNT, 16'($urandom_range(0, 31)));
                    write_reg(rmtm_pkg::CFG_TRIM_WINDOW, 16'($urandom_range(0, 31)));
                end
            endcase
            write_reg(rmtm_pkg::CFG_FILL_VALUE, 16'($urandom));
            if ($urandom_range(0, 1)) pending_items.push_back(make_reinit());
            queue_random(48);
            settle();
        end

        if (errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
